@@ rtl/mcs_pkg.sv @@
// shared types, codes and sizes for the motion command sequencer
`default_nettype none
package mcs_pkg;

	// queue size and derived widths
	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	// configuration register indexes
	localparam logic REG_SPEED_DELTA = 1'b0;
	localparam logic REG_STALL_LIMIT = 1'b1;
	localparam int CFG_W = 15;

	localparam logic [14:0] SPEED_DELTA_RST = 15'd64;
	localparam logic [7:0] STALL_LIMIT_RST = 8'd50;

	// item commands
	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_ADD_ABS = 2'd1;
	localparam logic [1:0] CMD_ADD_REL = 2'd2;
	localparam logic [1:0] CMD_ADD_CIRC = 2'd3;

	// path status codes
	localparam logic [1:0] STATUS_FINISHED = 2'd0;
	localparam logic [1:0] STATUS_BUSY = 2'd1;
	localparam logic [1:0] STATUS_BLOCKED = 2'd2;

	typedef struct packed {
		logic [1:0] cmd;
		logic signed [15:0] angle;
		logic signed [15:0] arc_radius;
		logic goal_reached;
		logic signed [15:0] left_speed;
		logic signed [15:0] right_speed;
		logic signed [15:0] left_target;
		logic signed [15:0] right_target;
	} item_t;

	typedef struct packed {
		logic [1:0] path_status;
		logic issue_valid;
		logic [1:0] issue_kind;
		logic signed [15:0] issue_angle;
		logic signed [15:0] issue_radius;
		logic stop_current;
		logic motors_off;
		logic stall_led;
	} result_t;

	// one queue entry
	typedef struct packed {
		logic [1:0] kind;
		logic [15:0] angle;
		logic [15:0] radius;
	} entry_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

endpackage
`default_nettype wire

@@ rtl/mcs_ctrl.sv @@
// controller state machine: accepts an item and sequences its evaluation
`default_nettype none
module mcs_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	output logic done,
	output mcs_pkg::ctrl_cmd_t ctrl
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic done_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == ST_EXEC);
		end
	end

	// commands to the datapath
	always_comb begin
		ctrl.load = (state_q == ST_IDLE) && start;
		ctrl.exec = (state_q == ST_EXEC);
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule
`default_nettype wire

@@ rtl/mcs_dp.sv @@
// datapath: command queue, sequencing registers, stall detection, result register
`default_nettype none
module mcs_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire mcs_pkg::ctrl_cmd_t ctrl,
	input wire mcs_pkg::item_t item,
	input wire logic cfg_we,
	input wire logic cfg_addr,
	input wire logic [mcs_pkg::CFG_W-1:0] cfg_wdata,
	output mcs_pkg::result_t result
);

	localparam int CNT_W = mcs_pkg::CNT_W;
	localparam int IDX_W = mcs_pkg::IDX_W;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(mcs_pkg::QUEUE_DEPTH);

	// queue memory
	mcs_pkg::entry_t mem [mcs_pkg::QUEUE_DEPTH];

	mcs_pkg::item_t item_q;
	mcs_pkg::entry_t rd_q;
	mcs_pkg::result_t res_q;
	mcs_pkg::result_t res_d;
	mcs_pkg::entry_t wr_entry;

	logic [14:0] speed_delta_q;
	logic [7:0] stall_limit_q;
	logic [CNT_W-1:0] next_q;
	logic [CNT_W-1:0] fill_q;
	logic active_q;
	logic [7:0] stall_q;
	logic [1:0] status_q;
	logic led_q;

	logic [CNT_W-1:0] next_d;
	logic [CNT_W-1:0] fill_d;
	logic active_d;
	logic [7:0] stall_d;
	logic [1:0] status_d;
	logic led_d;
	logic wr_en;

	logic [16:0] diff_l;
	logic [16:0] diff_r;
	logic [16:0] abs_l;
	logic [16:0] abs_r;
	logic stalled;
	logic blocked;
	logic do_advance;
	logic [7:0] stall_inc;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_delta_q <= mcs_pkg::SPEED_DELTA_RST;
			stall_limit_q <= mcs_pkg::STALL_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				mcs_pkg::REG_SPEED_DELTA: speed_delta_q <= cfg_wdata;
				mcs_pkg::REG_STALL_LIMIT: stall_limit_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// item latch and registered queue read of the next entry
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			item_q <= item;
			rd_q <= mem[next_q[IDX_W-1:0]];
		end
	end

	// queue write on add
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[fill_q[IDX_W-1:0]] <= wr_entry;
		end
	end

	// wheel speed errors
	always_comb begin
		diff_l = {item_q.left_speed[15], item_q.left_speed}
			- {item_q.left_target[15], item_q.left_target};
		diff_r = {item_q.right_speed[15], item_q.right_speed}
			- {item_q.right_target[15], item_q.right_target};
		abs_l = diff_l[16] ? (~diff_l + 17'd1) : diff_l;
		abs_r = diff_r[16] ? (~diff_r + 17'd1) : diff_r;
		stalled = (abs_l > {2'b00, speed_delta_q}) || (abs_r > {2'b00, speed_delta_q});
		stall_inc = (stall_q != 8'hFF) ? (stall_q + 8'd1) : stall_q;
	end

	// sequencing step
	always_comb begin
		next_d = next_q;
		fill_d = fill_q;
		active_d = active_q;
		stall_d = stall_q;
		status_d = status_q;
		led_d = led_q;
		wr_en = 1'b0;
		wr_entry.kind = item_q.cmd - 2'd1;
		wr_entry.angle = item_q.angle;
		wr_entry.radius = (item_q.cmd == mcs_pkg::CMD_ADD_CIRC) ? item_q.arc_radius : 16'd0;
		blocked = 1'b0;
		do_advance = 1'b0;
		res_d = '0;

		if (item_q.cmd != mcs_pkg::CMD_TICK) begin
			// add: append when room is left
			if (fill_q < DEPTH_C) begin
				wr_en = 1'b1;
				fill_d = fill_q + CNT_W'(1);
			end
		end else if (fill_q != '0) begin
			if (active_q) begin
				if (stalled) begin
					stall_d = stall_inc;
					blocked = (stall_inc >= stall_limit_q);
				end else begin
					led_d = 1'b0;
					stall_d = 8'd0;
				end
				if (blocked) begin
					// abort as blocked
					led_d = 1'b1;
					res_d.motors_off = 1'b1;
					res_d.stop_current = 1'b1;
					next_d = '0;
					fill_d = '0;
					status_d = mcs_pkg::STATUS_BLOCKED;
					stall_d = 8'd0;
					active_d = 1'b0;
				end else if (item_q.goal_reached) begin
					// retire the active command
					res_d.stop_current = 1'b1;
					active_d = 1'b0;
					do_advance = 1'b1;
				end
			end else begin
				do_advance = 1'b1;
			end

			if (do_advance) begin
				if (next_q < fill_q) begin
					res_d.issue_valid = 1'b1;
					res_d.issue_kind = rd_q.kind;
					res_d.issue_angle = rd_q.angle;
					res_d.issue_radius = rd_q.radius;
					active_d = 1'b1;
					status_d = mcs_pkg::STATUS_BUSY;
					next_d = next_q + CNT_W'(1);
				end else begin
					// queue exhausted
					res_d.motors_off = 1'b1;
					status_d = (stall_d >= stall_limit_q) ? mcs_pkg::STATUS_BLOCKED
						: mcs_pkg::STATUS_FINISHED;
					stall_d = 8'd0;
					next_d = '0;
					fill_d = '0;
					active_d = 1'b0;
				end
			end
		end

		res_d.path_status = status_d;
		res_d.stall_led = led_d;
	end

	// sequencing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q <= '0;
			fill_q <= '0;
			active_q <= 1'b0;
			stall_q <= 8'd0;
			status_q <= mcs_pkg::STATUS_FINISHED;
			led_q <= 1'b0;
		end else if (ctrl.exec) begin
			next_q <= next_d;
			fill_q <= fill_d;
			active_q <= active_d;
			stall_q <= stall_d;
			status_q <= status_d;
			led_q <= led_d;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			res_q <= res_d;
		end
	end

	assign result = res_q;

endmodule
`default_nettype wire

@@ rtl/motion_command_sequencer.sv @@
// top level of the motion command sequencer
// An item is transferred at a clock edge with start high and busy low. The block
// then holds busy high for one cycle while it evaluates the item. The result
// appears on the result port at the edge that ends that cycle and stays there,
// with done high, for exactly one cycle; the receiver cannot stall it, so it must
// take the result in that cycle. busy is low again while done is shown, so a new
// item can be transferred while the last result is shown. The evaluation cycle
// serves the queue memory, whose registered read of the next entry happens at the
// transfer edge and whose data is used in the evaluation cycle. Configuration
// writes take effect at the edge where cfg_we is high; the user must make them
// only while no item is in flight, as the block itself does not enforce this.
`default_nettype none
module motion_command_sequencer (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire mcs_pkg::item_t item,
	output logic done,
	output mcs_pkg::result_t result,
	input wire logic cfg_we,
	input wire logic cfg_addr,
	input wire logic [mcs_pkg::CFG_W-1:0] cfg_wdata
);

	mcs_pkg::ctrl_cmd_t ctrl;

	// control
	mcs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.done(done),
		.ctrl(ctrl)
	);

	// datapath
	mcs_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.item(item),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.result(result)
	);

endmodule
`default_nettype wire

@@ rtl/mcs_checker.sv @@
// port level checks for the motion command sequencer and their bind
`default_nettype none
module mcs_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire mcs_pkg::result_t result
);

	// a transfer makes the block busy on the next cycle
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after a transfer");

	// every transfer yields a result with done high
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result missing after a transfer");

	// a result only follows a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a preceding busy cycle");

	// issued command implies busy status, no issue implies zero issue fields
	a_issue_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.issue_valid) |-> (result.path_status == mcs_pkg::STATUS_BUSY))
		else $error("issued command without busy status");

	a_issue_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.issue_valid) |->
			(result.issue_kind == 2'd0 && result.issue_angle == 16'sd0
			&& result.issue_radius == 16'sd0))
		else $error("issue fields set without an issued command");

endmodule

bind motion_command_sequencer mcs_checker u_mcs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.result(result)
);
`default_nettype wire

@@ bench/motion_command_sequencer_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the motion command sequencer: directed and random items
module motion_command_sequencer_tb;

	localparam int IDLE_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	mcs_pkg::item_t item = '0;
	logic done;
	mcs_pkg::result_t result;
	logic cfg_we = 1'b0;
	logic cfg_addr = 1'b0;
	logic [mcs_pkg::CFG_W-1:0] cfg_wdata = '0;

	motion_command_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	// shadow copy of the sequencer state and registers
	logic [1:0] cmd_kind [mcs_pkg::QUEUE_DEPTH];
	logic [15:0] cmd_angle [mcs_pkg::QUEUE_DEPTH];
	logic [15:0] cmd_radius [mcs_pkg::QUEUE_DEPTH];
	int exec_idx = -1;
	int queued = 0;
	bit running = 1'b0;
	int stall_ticks = 0;
	logic [1:0] run_status = mcs_pkg::STATUS_FINISHED;
	bit lamp = 1'b0;
	logic [14:0] speed_delta = mcs_pkg::SPEED_DELTA_RST;
	logic [7:0] stall_limit = mcs_pkg::STALL_LIMIT_RST;

	mcs_pkg::item_t pending_items[$];
	mcs_pkg::result_t expected_results[$];
	int gap_pct = 38;
	int errors = 0;
	int quiet_cycles = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	// ends the run: motors off, active command off, queue emptied
	function automatic void abort_run(inout mcs_pkg::result_t r);
		r.motors_off = 1'b1;
		if (running)
			r.stop_current = 1'b1;
		exec_idx = -1;
		queued = 0;
		run_status = (stall_ticks >= int'(stall_limit)) ? mcs_pkg::STATUS_BLOCKED
			: mcs_pkg::STATUS_FINISHED;
		stall_ticks = 0;
		running = 1'b0;
	endfunction

	// issues the next queued command, or ends the run when none is left
	function automatic void next_command(inout mcs_pkg::result_t r);
		exec_idx++;
		if (exec_idx < queued && exec_idx < mcs_pkg::QUEUE_DEPTH) begin
			r.issue_valid = 1'b1;
			r.issue_kind = cmd_kind[exec_idx];
			r.issue_angle = cmd_angle[exec_idx];
			r.issue_radius = cmd_radius[exec_idx];
			running = 1'b1;
			run_status = mcs_pkg::STATUS_BUSY;
		end else
			abort_run(r);
	endfunction

	function automatic int wheel_error(logic signed [15:0] spd, logic signed [15:0] tgt);
		int d;
		d = int'(spd) - int'(tgt);
		return (d < 0) ? -d : d;
	endfunction

	// expected result of one transferred item, updating the shadow state
	function automatic mcs_pkg::result_t predict_item(mcs_pkg::item_t it);
		mcs_pkg::result_t r;
		bit blocked;
		r = '0;
		blocked = 1'b0;
		if (it.cmd != mcs_pkg::CMD_TICK) begin
			// adds are dropped once the queue is full
			if (queued < mcs_pkg::QUEUE_DEPTH) begin
				cmd_kind[queued] = it.cmd - 2'd1;
				cmd_angle[queued] = it.angle;
				cmd_radius[queued] = (it.cmd == mcs_pkg::CMD_ADD_CIRC) ? it.arc_radius
					: 16'd0;
				queued++;
			end
		end else if (queued > 0) begin
			if (running) begin
				// stall check on both wheels
				if (wheel_error(it.left_speed, it.left_target) > int'(speed_delta) ||
						wheel_error(it.right_speed, it.right_target) > int'(speed_delta)) begin
					if (stall_ticks < 255)
						stall_ticks++;
					blocked = (stall_ticks >= int'(stall_limit));
				end else begin
					lamp = 1'b0;
					stall_ticks = 0;
				end
				if (blocked) begin
					lamp = 1'b1;
					abort_run(r);
				end else if (it.goal_reached) begin
					r.stop_current = 1'b1;
					running = 1'b0;
					run_status = mcs_pkg::STATUS_FINISHED;
					next_command(r);
				end
			end else
				next_command(r);
		end
		r.path_status = run_status;
		r.stall_led = lamp;
		return r;
	endfunction

	function automatic logic [15:0] rand16();
		return 16'($urandom);
	endfunction

	function automatic mcs_pkg::item_t make_add(logic [1:0] kind, logic [15:0] angle,
			logic [15:0] radius);
		mcs_pkg::item_t it;
		it.cmd = kind;
		it.angle = angle;
		it.arc_radius = radius;
		it.goal_reached = 1'($urandom);
		it.left_speed = rand16();
		it.right_speed = rand16();
		it.left_target = rand16();
		it.right_target = rand16();
		return it;
	endfunction

	function automatic mcs_pkg::item_t make_tick(bit goal, logic [15:0] ls, logic [15:0] lt,
			logic [15:0] rs, logic [15:0] rt);
		mcs_pkg::item_t it;
		it.cmd = mcs_pkg::CMD_TICK;
		it.angle = rand16();
		it.arc_radius = rand16();
		it.goal_reached = goal;
		it.left_speed = ls;
		it.left_target = lt;
		it.right_speed = rs;
		it.right_target = rt;
		return it;
	endfunction

	// one wheel's speed and target, apart by more than speed_delta when stalled
	function automatic void wheel_pair(input bit stalled, output logic [15:0] spd,
			output logic [15:0] tgt);
		int unsigned offset;
		int lo;
		if (stalled)
			offset = ($urandom_range(0, 3) == 0) ? speed_delta + 1 :
				$urandom_range(speed_delta + 1, 65535);
		else
			offset = ($urandom_range(0, 3) == 0) ? speed_delta :
				$urandom_range(0, speed_delta);
		lo = int'($urandom_range(0, 65535 - offset)) - 32768;
		if ($urandom_range(0, 1)) begin
			spd = 16'(lo + int'(offset));
			tgt = 16'(lo);
		end else begin
			spd = 16'(lo);
			tgt = 16'(lo + int'(offset));
		end
	endfunction

	function automatic mcs_pkg::item_t random_tick(int stall_pct, int goal_pct);
		logic [1:0] stalled;
		logic [15:0] ls, lt, rs, rt;
		stalled = ($urandom_range(1, 100) <= stall_pct) ? 2'($urandom_range(1, 3)) : 2'b00;
		wheel_pair(stalled[0], ls, lt);
		wheel_pair(stalled[1], rs, rt);
		return make_tick($urandom_range(1, 100) <= goal_pct, ls, lt, rs, rt);
	endfunction

	// mostly bursts of adds followed by ticks that run them, with some noise
	task automatic queue_random(int count);
		int added;
		int n_adds;
		int n_ticks;
		int stall_pct;
		logic [127:0] raw;
		added = 0;
		while (added < count) begin
			if ($urandom_range(1, 100) <= 15) begin
				raw = {$urandom, $urandom, $urandom, $urandom};
				pending_items.push_back(raw[$bits(mcs_pkg::item_t)-1:0]);
				added++;
			end else begin
				n_adds = ($urandom_range(0, 7) == 0) ?
					$urandom_range(mcs_pkg::QUEUE_DEPTH - 2, mcs_pkg::QUEUE_DEPTH + 4)
					: $urandom_range(1, 5);
				n_ticks = n_adds * $urandom_range(2, 4) + $urandom_range(0, 3);
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 20;
					default: stall_pct = 75;
				endcase
				repeat (n_adds)
					pending_items.push_back(make_add(2'($urandom_range(1, 3)), rand16(),
						rand16()));
				repeat (n_ticks)
					pending_items.push_back(random_tick(stall_pct, 35));
				added += n_adds + n_ticks;
			end
		end
	endtask

	task automatic report_mismatch(string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want)
			report_mismatch($sformatf("%s: expected %h, got %h", name, want, got));
	endtask

	task automatic check_result(mcs_pkg::result_t want, mcs_pkg::result_t got);
		compare_field("path_status", 16'(want.path_status), 16'(got.path_status));
		compare_field("issue_valid", 16'(want.issue_valid), 16'(got.issue_valid));
		compare_field("issue_kind", 16'(want.issue_kind), 16'(got.issue_kind));
		compare_field("issue_angle", want.issue_angle, got.issue_angle);
		compare_field("issue_radius", want.issue_radius, got.issue_radius);
		compare_field("stop_current", 16'(want.stop_current), 16'(got.stop_current));
		compare_field("motors_off", 16'(want.motors_off), 16'(got.motors_off));
		compare_field("stall_led", 16'(want.stall_led), 16'(got.stall_led));
	endtask

	// register write, mirrored into the shadow registers at the write edge
	task automatic write_reg(logic addr, logic [mcs_pkg::CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (addr == mcs_pkg::REG_SPEED_DELTA)
			speed_delta = data[14:0];
		else
			stall_limit = data[7:0];
	endtask

	// wait until every item is transferred and every result is back
	task automatic drain();
		do
			@(posedge clk);
		while (pending_items.size() > 0 || start || expected_results.size() > 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// driver: holds start until the transfer, then takes the next item or idles
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				expected_results.push_back(predict_item(item));
			if (!start || !busy) begin
				if (pending_items.size() > 0 && $urandom_range(1, 100) > gap_pct) begin
					item <= pending_items.pop_front();
					start <= 1'b1;
				end else
					start <= 1'b0;
			end
		end
	end

	// monitor: each result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0)
				report_mismatch("result with no item outstanding");
			else
				check_result(expected_results.pop_front(), result);
		end
	end

	// watchdog on cycles without any transfer, result or register write
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// stimulus phases
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values: every command, field extremes, delta boundaries
		pending_items.push_back(make_tick(1'b1, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF));
		pending_items.push_back(make_add(mcs_pkg::CMD_ADD_ABS, 16'h7FFF, 16'hFFFF));
		pending_items.push_back(make_add(mcs_pkg::CMD_ADD_REL, 16'h8000, 16'h7FFF));
		pending_items.push_back(make_add(mcs_pkg::CMD_ADD_CIRC, 16'h0001, 16'h8000));
		pending_items.push_back(make_add(mcs_pkg::CMD_ADD_CIRC, 16'hFFFF, 16'h7FFF));
		pending_items.push_back(make_tick(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		pending_items.push_back(make_tick(1'b0, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000));
		pending_items.push_back(make_tick(1'b1, 16'd100, 16'd36, 16'hFFC0, 16'h0000));
		pending_items.push_back(make_tick(1'b1, 16'h0000, 16'h0000, 16'd65, 16'h0000));
		pending_items.push_back(make_tick(1'b1, 16'h1234, 16'h1234, 16'h8000, 16'h8000));
		pending_items.push_back(make_tick(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		pending_items.push_back(make_tick(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		drain();

		// zero stall limit: abort on the first stall, lamp kept across add and issue
		write_reg(mcs_pkg::REG_SPEED_DELTA, 15'd0);
		write_reg(mcs_pkg::REG_STALL_LIMIT, {7'($urandom), 8'd0});
		pending_items.push_back(make_add(mcs_pkg::CMD_ADD_ABS, 16'h0100, 16'h0000));
		pending_items.push_back(make_tick(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		pending_items.push_back(make_tick(1'b1, 16'h0001, 16'h0000, 16'h0000, 16'h0000));
		pending_items.push_back(make_add(mcs_pkg::CMD_ADD_REL, 16'hF000, 16'h5555));
		pending_items.push_back(make_tick(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		pending_items.push_back(make_tick(1'b0, 16'h4000, 16'h4000, 16'hC000, 16'hC000));
		pending_items.push_back(make_tick(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		queue_random(150);
		drain();

		// widest delta, highest limit
		write_reg(mcs_pkg::REG_SPEED_DELTA, 15'h7FFF);
		write_reg(mcs_pkg::REG_STALL_LIMIT, {7'($urandom), 8'd255});
		queue_random(200);
		drain();

		// back-to-back stretch with a limit of one
		gap_pct = 0;
		write_reg(mcs_pkg::REG_SPEED_DELTA, 15'($urandom_range(16, 400)));
		write_reg(mcs_pkg::REG_STALL_LIMIT, {7'($urandom), 8'd1});
		queue_random(150);
		drain();
		gap_pct = 38;

		// small limits so that blocked runs are frequent
		write_reg(mcs_pkg::REG_SPEED_DELTA, 15'($urandom_range(0, 2000)));
		write_reg(mcs_pkg::REG_STALL_LIMIT, {7'($urandom), 8'($urandom_range(2, 8))});
		queue_random(250);
		drain();

		write_reg(mcs_pkg::REG_SPEED_DELTA, 15'd0);
		write_reg(mcs_pkg::REG_STALL_LIMIT, {7'($urandom), 8'($urandom_range(1, 255))});
		queue_random(180);
		drain();

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
